>>> rtl/shlex_pkg.sv
// shared types and constants of the shell command line lexer
package shlex_pkg;

   localparam int MAX_WORDS     = 32;
   localparam int WORD_CAPACITY = 256;
   localparam int WLEN_W        = $clog2(WORD_CAPACITY);
   localparam logic [WLEN_W-1:0] WLEN_MAX = WLEN_W'(WORD_CAPACITY - 1);
   localparam int WCNT_W        = 6;
   localparam int MAX_RES       = 4;
   localparam int RES_IDX_W     = $clog2(MAX_RES);
   localparam int RES_CNT_W     = $clog2(MAX_RES + 1);
   localparam int LEX_PASSES    = 4;
   localparam int Q_DEPTH       = 2;
   localparam int Q_PTR_W       = $clog2(Q_DEPTH);
   localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_BAR    = 8'h7C;

   localparam logic [1:0] SEP_LINE = 2'd0;
   localparam logic [1:0] SEP_SEMI = 2'd1;
   localparam logic [1:0] SEP_AND  = 2'd2;
   localparam logic [1:0] SEP_OR   = 2'd3;

   localparam logic [1:0] ERR_OPERATOR  = 2'd0;
   localparam logic [1:0] ERR_WORDS     = 2'd1;
   localparam logic [1:0] ERR_QUOTE     = 2'd2;
   localparam logic [1:0] ERR_BACKSLASH = 2'd3;

   typedef enum logic [3:0] {
      ST_SPACE     = 4'd0,
      ST_WORD      = 4'd1,
      ST_SQ        = 4'd2,
      ST_DQ        = 4'd3,
      ST_BS        = 4'd4,
      ST_DQ_BS     = 4'd5,
      ST_DOLLAR    = 4'd6,
      ST_DQ_DOLLAR = 4'd7,
      ST_NAME      = 4'd8,
      ST_DQ_NAME   = 4'd9,
      ST_AMP       = 4'd10,
      ST_BAR       = 4'd11,
      ST_COMMENT   = 4'd12,
      ST_DROP      = 4'd13
   } lex_state_type;

   typedef enum logic [2:0] {
      KIND_WORD_BYTE = 3'd0,
      KIND_WORD_END  = 3'd1,
      KIND_NAME_BYTE = 3'd2,
      KIND_NAME_END  = 3'd3,
      KIND_CMD_END   = 3'd4,
      KIND_ERROR     = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        out_byte;
      logic [1:0]        sep_code;
      logic [WCNT_W-1:0] word_total;
      logic [1:0]        error_code;
   } result_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]       count;
      result_type [MAX_RES-1:0]   items;
   } bundle_type;

   typedef struct packed {
      logic [3:0] hundreds;
      logic [3:0] tens;
      logic [3:0] ones;
   } status_digits_type;

endpackage

>>> rtl/shlex_front.sv
// front end: accepts characters and turns each into a bundle of results
module shlex_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_char_in,
   input  shlex_pkg::status_digits_type  digits,
   input  logic                          q_space,
   output logic                          q_push,
   output shlex_pkg::bundle_type         q_bundle
);

   shlex_pkg::lex_state_type              st_ff, st_in;
   logic [shlex_pkg::WLEN_W-1:0]          wl_ff, wl_in;
   logic [shlex_pkg::WCNT_W-1:0]          wc_ff, wc_in;
   logic                                  qf_ff, qf_in;
   logic                                  wa_ff, wa_in;
   shlex_pkg::bundle_type                 bundle;
   logic                                  accept;

   function automatic shlex_pkg::bundle_type push(
      input shlex_pkg::bundle_type       b,
      input shlex_pkg::kind_type         k,
      input logic [7:0]                  byte_v,
      input logic [1:0]                  sep,
      input logic [shlex_pkg::WCNT_W-1:0] total,
      input logic [1:0]                  err
   );
      shlex_pkg::bundle_type r;
      r = b;
      if (r.count < shlex_pkg::RES_CNT_W'(shlex_pkg::MAX_RES)) begin
         r.items[r.count[shlex_pkg::RES_IDX_W-1:0]] = '{kind: k, out_byte: byte_v,
            sep_code: sep, word_total: total, error_code: err};
         r.count = r.count + 1'b1;
      end
      return r;
   endfunction

   function automatic shlex_pkg::bundle_type put_byte(
      input shlex_pkg::bundle_type       b,
      input logic [shlex_pkg::WLEN_W-1:0] wl,
      input logic [7:0]                  byte_v
   );
      shlex_pkg::bundle_type r;
      r = b;
      if (wl < shlex_pkg::WLEN_MAX) begin
         r = push(b, shlex_pkg::KIND_WORD_BYTE, byte_v, 2'd0, '0, 2'd0);
      end
      return r;
   endfunction

   function automatic logic name_start(input logic [7:0] c);
      return (c >= shlex_pkg::CH_UPPER_A && c <= shlex_pkg::CH_UPPER_Z) ||
             (c >= shlex_pkg::CH_LOWER_A && c <= shlex_pkg::CH_LOWER_Z) ||
             (c == shlex_pkg::CH_UNDER);
   endfunction

   function automatic logic name_char(input logic [7:0] c);
      return name_start(c) || (c >= shlex_pkg::CH_ZERO && c <= shlex_pkg::CH_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == shlex_pkg::CH_SPACE) || (c == shlex_pkg::CH_TAB);
   endfunction

   always_comb begin
      shlex_pkg::lex_state_type      st;
      logic [shlex_pkg::WLEN_W-1:0]  wl;
      logic [shlex_pkg::WCNT_W-1:0]  wc;
      logic                          qf;
      logic                          wa;
      logic                          run;
      logic                          again;
      logic [7:0]                    c;
      logic                          dq;
      shlex_pkg::bundle_type         b;
      c   = req_char_in;
      st  = st_ff;
      wl  = wl_ff;
      wc  = wc_ff;
      qf  = qf_ff;
      wa  = wa_ff;
      b   = '0;
      run = 1'b1;
      for (int pass = 0; pass < shlex_pkg::LEX_PASSES; pass++) begin
         again = 1'b0;
         dq    = 1'b0;
         if (run) begin
            unique case (st)
               shlex_pkg::ST_WORD: begin
                  if (c == shlex_pkg::CH_NUL || is_space(c) || c == shlex_pkg::CH_SEMI ||
                      c == shlex_pkg::CH_AMP || c == shlex_pkg::CH_BAR ||
                      c == shlex_pkg::CH_HASH) begin
                     if (wa && (wl != '0 || qf)) begin
                        wc = wc + 1'b1;
                        b  = push(b, shlex_pkg::KIND_WORD_END, 8'd0, 2'd0, wc, 2'd0);
                     end
                     wa    = 1'b0;
                     wl    = '0;
                     qf    = 1'b0;
                     st    = shlex_pkg::ST_SPACE;
                     again = 1'b1;
                  end else if (c == shlex_pkg::CH_SQUOTE) begin
                     qf = 1'b1;
                     st = shlex_pkg::ST_SQ;
                  end else if (c == shlex_pkg::CH_DQUOTE) begin
                     qf = 1'b1;
                     st = shlex_pkg::ST_DQ;
                  end else if (c == shlex_pkg::CH_BSLASH) begin
                     st = shlex_pkg::ST_BS;
                  end else if (c == shlex_pkg::CH_DOLLAR) begin
                     st = shlex_pkg::ST_DOLLAR;
                  end else begin
                     b  = put_byte(b, wl, c);
                     wl = wl + shlex_pkg::WLEN_W'(wl < shlex_pkg::WLEN_MAX);
                  end
               end
               shlex_pkg::ST_SQ, shlex_pkg::ST_DQ, shlex_pkg::ST_BS: begin
                  if (c == shlex_pkg::CH_NUL) begin
                     b  = push(b, shlex_pkg::KIND_ERROR, 8'd0, 2'd0, '0,
                               (st == shlex_pkg::ST_BS) ? shlex_pkg::ERR_BACKSLASH
                                                        : shlex_pkg::ERR_QUOTE);
                     wa = 1'b0;
                     wl = '0;
                     qf = 1'b0;
                     wc = '0;
                     st = shlex_pkg::ST_SPACE;
                  end else if (st == shlex_pkg::ST_BS) begin
                     b  = put_byte(b, wl, c);
                     wl = wl + shlex_pkg::WLEN_W'(wl < shlex_pkg::WLEN_MAX);
                     st = shlex_pkg::ST_WORD;
                  end else if (st == shlex_pkg::ST_SQ && c == shlex_pkg::CH_SQUOTE) begin
                     st = shlex_pkg::ST_WORD;
                  end else if (st == shlex_pkg::ST_DQ && c == shlex_pkg::CH_DQUOTE) begin
                     st = shlex_pkg::ST_WORD;
                  end else if (st == shlex_pkg::ST_DQ && c == shlex_pkg::CH_BSLASH) begin
                     st = shlex_pkg::ST_DQ_BS;
                  end else if (st == shlex_pkg::ST_DQ && c == shlex_pkg::CH_DOLLAR) begin
                     st = shlex_pkg::ST_DQ_DOLLAR;
                  end else begin
                     b  = put_byte(b, wl, c);
                     wl = wl + shlex_pkg::WLEN_W'(wl < shlex_pkg::WLEN_MAX);
                  end
               end
               shlex_pkg::ST_DQ_BS: begin
                  st = shlex_pkg::ST_DQ;
                  if (c == shlex_pkg::CH_DQUOTE || c == shlex_pkg::CH_BSLASH ||
                      c == shlex_pkg::CH_DOLLAR) begin
                     b = put_byte(b, wl, c);
                  end else begin
                     b     = put_byte(b, wl, shlex_pkg::CH_BSLASH);
                     again = 1'b1;
                  end
                  wl = wl + shlex_pkg::WLEN_W'(wl < shlex_pkg::WLEN_MAX);
               end
               shlex_pkg::ST_DOLLAR, shlex_pkg::ST_DQ_DOLLAR: begin
                  dq = (st == shlex_pkg::ST_DQ_DOLLAR);
                  if (c == shlex_pkg::CH_QUEST) begin
                     if (digits.hundreds != 4'd0) begin
                        b  = put_byte(b, wl, shlex_pkg::CH_ZERO + 8'(digits.hundreds));
                        wl = wl + shlex_pkg::WLEN_W'(wl < shlex_pkg::WLEN_MAX);
                     end
                     if (digits.hundreds != 4'd0 || digits.tens != 4'd0) begin
                        b  = put_byte(b, wl, shlex_pkg::CH_ZERO + 8'(digits.tens));
                        wl = wl + shlex_pkg::WLEN_W'(wl < shlex_pkg::WLEN_MAX);
                     end
                     b  = put_byte(b, wl, shlex_pkg::CH_ZERO + 8'(digits.ones));
                     wl = wl + shlex_pkg::WLEN_W'(wl < shlex_pkg::WLEN_MAX);
                     st = dq ? shlex_pkg::ST_DQ : shlex_pkg::ST_WORD;
                  end else if (name_start(c)) begin
                     qf = 1'b1;
                     b  = push(b, shlex_pkg::KIND_NAME_BYTE, c, 2'd0, '0, 2'd0);
                     st = dq ? shlex_pkg::ST_DQ_NAME : shlex_pkg::ST_NAME;
                  end else begin
                     b     = put_byte(b, wl, shlex_pkg::CH_DOLLAR);
                     wl    = wl + shlex_pkg::WLEN_W'(wl < shlex_pkg::WLEN_MAX);
                     st    = dq ? shlex_pkg::ST_DQ : shlex_pkg::ST_WORD;
                     again = 1'b1;
                  end
               end
               shlex_pkg::ST_NAME, shlex_pkg::ST_DQ_NAME: begin
                  if (name_char(c)) begin
                     b = push(b, shlex_pkg::KIND_NAME_BYTE, c, 2'd0, '0, 2'd0);
                  end else begin
                     b     = push(b, shlex_pkg::KIND_NAME_END, 8'd0, 2'd0, '0, 2'd0);
                     st    = (st == shlex_pkg::ST_NAME) ? shlex_pkg::ST_WORD
                                                        : shlex_pkg::ST_DQ;
                     again = 1'b1;
                  end
               end
               shlex_pkg::ST_AMP, shlex_pkg::ST_BAR: begin
                  if ((st == shlex_pkg::ST_AMP && c == shlex_pkg::CH_AMP) ||
                      (st == shlex_pkg::ST_BAR && c == shlex_pkg::CH_BAR)) begin
                     b  = push(b, shlex_pkg::KIND_CMD_END, 8'd0,
                               (st == shlex_pkg::ST_AMP) ? shlex_pkg::SEP_AND
                                                         : shlex_pkg::SEP_OR,
                               wc, 2'd0);
                     wc = '0;
                     st = shlex_pkg::ST_SPACE;
                  end else begin
                     b  = push(b, shlex_pkg::KIND_ERROR, 8'd0, 2'd0, '0,
                               shlex_pkg::ERR_OPERATOR);
                     wa = 1'b0;
                     wl = '0;
                     qf = 1'b0;
                     wc = '0;
                     st = (c == shlex_pkg::CH_NUL) ? shlex_pkg::ST_SPACE
                                                   : shlex_pkg::ST_DROP;
                  end
               end
               shlex_pkg::ST_COMMENT: begin
                  if (c == shlex_pkg::CH_NUL) begin
                     b  = push(b, shlex_pkg::KIND_CMD_END, 8'd0, shlex_pkg::SEP_LINE,
                               wc, 2'd0);
                     wc = '0;
                     st = shlex_pkg::ST_SPACE;
                  end
               end
               shlex_pkg::ST_DROP: begin
                  if (c == shlex_pkg::CH_NUL) begin
                     st = shlex_pkg::ST_SPACE;
                  end
               end
               default: begin
                  st = shlex_pkg::ST_SPACE;
                  if (is_space(c)) begin
                     st = shlex_pkg::ST_SPACE;
                  end else if (c == shlex_pkg::CH_NUL || c == shlex_pkg::CH_SEMI) begin
                     b  = push(b, shlex_pkg::KIND_CMD_END, 8'd0,
                               (c == shlex_pkg::CH_NUL) ? shlex_pkg::SEP_LINE
                                                        : shlex_pkg::SEP_SEMI,
                               wc, 2'd0);
                     wc = '0;
                  end else if (c == shlex_pkg::CH_HASH) begin
                     st = shlex_pkg::ST_COMMENT;
                  end else if (c == shlex_pkg::CH_AMP) begin
                     st = shlex_pkg::ST_AMP;
                  end else if (c == shlex_pkg::CH_BAR) begin
                     st = shlex_pkg::ST_BAR;
                  end else if (wc >= shlex_pkg::WCNT_W'(shlex_pkg::MAX_WORDS)) begin
                     b  = push(b, shlex_pkg::KIND_ERROR, 8'd0, 2'd0, '0,
                               shlex_pkg::ERR_WORDS);
                     wa = 1'b0;
                     wl = '0;
                     qf = 1'b0;
                     wc = '0;
                     st = shlex_pkg::ST_DROP;
                  end else begin
                     wa    = 1'b1;
                     wl    = '0;
                     qf    = 1'b0;
                     st    = shlex_pkg::ST_WORD;
                     again = 1'b1;
                  end
               end
            endcase
         end
         run = run & again;
      end
      st_in  = st;
      wl_in  = wl;
      wc_in  = wc;
      qf_in  = qf;
      wa_in  = wa;
      bundle = b;
   end

   assign req_ready = q_space;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && (bundle.count != '0);
   assign q_bundle  = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= shlex_pkg::ST_SPACE;
         wl_ff <= '0;
         wc_ff <= '0;
         qf_ff <= 1'b0;
         wa_ff <= 1'b0;
      end else if (accept) begin
         st_ff <= st_in;
         wl_ff <= wl_in;
         wc_ff <= wc_in;
         qf_ff <= qf_in;
         wa_ff <= wa_in;
      end
   end

endmodule

>>> rtl/shlex_queue.sv
// short queue of result bundles between front and back end
module shlex_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  shlex_pkg::bundle_type  push_bundle,
   output logic                   space,
   input  logic                   pop,
   output logic                   nonempty,
   output shlex_pkg::bundle_type  head
);

   shlex_pkg::bundle_type              mem_ff [shlex_pkg::Q_DEPTH];
   logic [shlex_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [shlex_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [shlex_pkg::Q_CNT_W-1:0]      count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign space    = (count_ff != shlex_pkg::Q_CNT_W'(shlex_pkg::Q_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = mem_ff[rd_ptr_ff];
   assign do_push  = push && space;
   assign do_pop   = pop && nonempty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == shlex_pkg::Q_PTR_W'(shlex_pkg::Q_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == shlex_pkg::Q_PTR_W'(shlex_pkg::Q_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

>>> rtl/shlex_back.sv
// back end: sends the results of each bundle out one per cycle while rsp_ready is high
module shlex_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_nonempty,
   input  shlex_pkg::bundle_type         q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_kind,
   output logic [7:0]                    rsp_out_byte,
   output logic [1:0]                    rsp_sep_code,
   output logic [shlex_pkg::WCNT_W-1:0]  rsp_word_total,
   output logic [1:0]                    rsp_error_code,
   output logic                          rsp_last
);

   logic [shlex_pkg::RES_IDX_W-1:0]  idx_ff, idx_in;
   logic                             valid_ff, valid_in;
   shlex_pkg::result_type            item_ff;
   logic                             last_ff;
   logic                             load;
   logic                             is_last;

   assign load    = q_nonempty && (!valid_ff || rsp_ready);
   assign is_last = (shlex_pkg::RES_CNT_W'(idx_ff) + 1'b1) == q_head.count;
   assign q_pop   = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= q_head.items[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = item_ff.kind;
   assign rsp_out_byte   = item_ff.out_byte;
   assign rsp_sep_code   = item_ff.sep_code;
   assign rsp_word_total = item_ff.word_total;
   assign rsp_error_code = item_ff.error_code;
   assign rsp_last       = last_ff;

endmodule

>>> rtl/shell_command_line_lexer_top.sv
// top level of the shell command line lexer
// path: the first result of a character passes the bundle queue, then the output register
// throughput: one character per cycle into the front end while the bundle queue has room;
// the back end sends one result per cycle while rsp_ready is high; a character yields up
// to four results, and characters without results are not queued
// reset: synchronous, clears lexer state, queue and output valid, last_status reads as 0
module shell_command_line_lexer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_char_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_kind,
   output logic [7:0]                    rsp_out_byte,
   output logic [1:0]                    rsp_sep_code,
   output logic [shlex_pkg::WCNT_W-1:0]  rsp_word_total,
   output logic [1:0]                    rsp_error_code,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [7:0]                    csr_last_status
);

   shlex_pkg::status_digits_type  digits_ff, digits_in;
   logic [13:0]                   hund_prod;
   logic [6:0]                    rem;
   logic [14:0]                   tens_prod;
   logic [3:0]                    hund;
   logic [3:0]                    tens;
   logic                          q_space;
   logic                          q_push;
   shlex_pkg::bundle_type         q_bundle;
   logic                          q_pop;
   logic                          q_nonempty;
   shlex_pkg::bundle_type         q_head;

   assign csr_ready = 1'b1;

   // decimal digits of the status by reciprocal multiply
   always_comb begin
      hund_prod = 14'(csr_last_status) * 14'd41;
      hund      = 4'(hund_prod[13:12]);
      rem       = 7'(csr_last_status - 8'(hund) * 8'd100);
      tens_prod = 15'(rem) * 15'd205;
      tens      = tens_prod[14:11];
      digits_in = '{hundreds: hund, tens: tens, ones: 4'(rem - 7'(tens) * 7'd10)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         digits_ff <= digits_in;
      end
   end

   shlex_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .digits      (digits_ff),
      .q_space     (q_space),
      .q_push      (q_push),
      .q_bundle    (q_bundle)
   );

   shlex_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_bundle (q_bundle),
      .space       (q_space),
      .pop         (q_pop),
      .nonempty    (q_nonempty),
      .head        (q_head)
   );

   shlex_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_nonempty     (q_nonempty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_sep_code   (rsp_sep_code),
      .rsp_word_total (rsp_word_total),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   a_digits_match: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=>
         (10'(digits_ff.hundreds) * 10'd100 + 10'(digits_ff.tens) * 10'd10 +
          10'(digits_ff.ones)) == 10'($past(csr_last_status)))
      else $error("status digits do not match written status");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_nonempty)
      else $error("back end pops an empty queue");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_space && q_bundle.count != '0)
      else $error("front end pushes without room or with an empty bundle");

   a_word_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 3'(shlex_pkg::KIND_CMD_END) |->
         rsp_word_total <= shlex_pkg::WCNT_W'(shlex_pkg::MAX_WORDS))
      else $error("command end reports too many words");
`endif

endmodule

>>> test/shlex_checker.sv
// checker of the shell command line lexer: predicts each transaction's results and compares
`timescale 1ns / 1ps
module shlex_checker
   import shlex_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_char_in,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [2:0]        rsp_kind,
   input  logic [7:0]        rsp_out_byte,
   input  logic [1:0]        rsp_sep_code,
   input  logic [WCNT_W-1:0] rsp_word_total,
   input  logic [1:0]        rsp_error_code,
   input  logic              rsp_last,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [7:0]        csr_last_status,
   output int                failures,
   output int                pending
);

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        out_byte;
      logic [1:0]        sep_code;
      logic [WCNT_W-1:0] word_total;
      logic [1:0]        error_code;
      logic              last;
   } token_t;

   token_t expected_tokens[$];
   token_t char_tokens[$];

   lex_state_type     lex_st;
   logic [7:0]        word_len;
   logic [WCNT_W-1:0] word_cnt;
   logic              quoted;
   logic              in_word;
   logic [7:0]        status;
   int                fail_tally;

   function automatic void push_token(kind_type k, logic [7:0] b, logic [1:0] s,
                                      logic [WCNT_W-1:0] t, logic [1:0] e);
      token_t tok;
      if (char_tokens.size() < MAX_RES) begin
         tok = '{kind: k, out_byte: b, sep_code: s, word_total: t, error_code: e, last: 1'b0};
         char_tokens.push_back(tok);
      end
   endfunction

   function automatic void word_byte(logic [7:0] c);
      if (int'(word_len) + 1 < WORD_CAPACITY) begin
         push_token(KIND_WORD_BYTE, c, 2'd0, '0, 2'd0);
         word_len = word_len + 8'd1;
      end
   endfunction

   function automatic void close_word();
      if (in_word && (word_len != 8'd0 || quoted)) begin
         word_cnt = word_cnt + 1'b1;
         push_token(KIND_WORD_END, 8'd0, 2'd0, word_cnt, 2'd0);
      end
      in_word  = 1'b0;
      word_len = 8'd0;
      quoted   = 1'b0;
   endfunction

   function automatic void close_command(logic [1:0] sep);
      push_token(KIND_CMD_END, 8'd0, sep, word_cnt, 2'd0);
      word_cnt = '0;
   endfunction

   function automatic void abort_line(logic [1:0] code, logic [7:0] c);
      push_token(KIND_ERROR, 8'd0, 2'd0, '0, code);
      in_word  = 1'b0;
      word_len = 8'd0;
      quoted   = 1'b0;
      word_cnt = '0;
      if (c == CH_NUL) lex_st = ST_SPACE;
      else lex_st = ST_DROP;
   endfunction

   function automatic void status_digits();
      logic [7:0] v;
      v = status;
      if (v >= 8'd100) word_byte(CH_ZERO + v / 8'd100);
      if (v >= 8'd10) word_byte(CH_ZERO + (v / 8'd10) % 8'd10);
      word_byte(CH_ZERO + v % 8'd10);
   endfunction

   function automatic bit name_first(logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
             c == CH_UNDER;
   endfunction

   function automatic bit name_rest(logic [7:0] c);
      return name_first(c) || (c >= CH_ZERO && c <= CH_NINE);
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic void lex_char(logic [7:0] c);
      bit again;
      bit in_dq;
      char_tokens.delete();
      for (int round = 0; round < 8; round++) begin
         again = 1'b0;
         case (lex_st)
            ST_WORD: begin
               if (c == CH_NUL || is_blank(c) || c == CH_SEMI || c == CH_AMP ||
                   c == CH_BAR || c == CH_HASH) begin
                  close_word();
                  lex_st = ST_SPACE;
                  again  = 1'b1;
               end else if (c == CH_SQUOTE) begin
                  quoted = 1'b1;
                  lex_st = ST_SQ;
               end else if (c == CH_DQUOTE) begin
                  quoted = 1'b1;
                  lex_st = ST_DQ;
               end else if (c == CH_BSLASH) begin
                  lex_st = ST_BS;
               end else if (c == CH_DOLLAR) begin
                  lex_st = ST_DOLLAR;
               end else begin
                  word_byte(c);
               end
            end
            ST_SQ: begin
               if (c == CH_NUL) abort_line(ERR_QUOTE, c);
               else if (c == CH_SQUOTE) lex_st = ST_WORD;
               else word_byte(c);
            end
            ST_DQ: begin
               if (c == CH_NUL) abort_line(ERR_QUOTE, c);
               else if (c == CH_DQUOTE) lex_st = ST_WORD;
               else if (c == CH_BSLASH) lex_st = ST_DQ_BS;
               else if (c == CH_DOLLAR) lex_st = ST_DQ_DOLLAR;
               else word_byte(c);
            end
            ST_BS: begin
               if (c == CH_NUL) begin
                  abort_line(ERR_BACKSLASH, c);
               end else begin
                  word_byte(c);
                  lex_st = ST_WORD;
               end
            end
            ST_DQ_BS: begin
               lex_st = ST_DQ;
               if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR) begin
                  word_byte(c);
               end else begin
                  word_byte(CH_BSLASH);
                  again = 1'b1;
               end
            end
            ST_DOLLAR, ST_DQ_DOLLAR: begin
               in_dq = (lex_st == ST_DQ_DOLLAR);
               if (c == CH_QUEST) begin
                  status_digits();
                  lex_st = in_dq ? ST_DQ : ST_WORD;
               end else if (name_first(c)) begin
                  quoted = 1'b1;
                  push_token(KIND_NAME_BYTE, c, 2'd0, '0, 2'd0);
                  lex_st = in_dq ? ST_DQ_NAME : ST_NAME;
               end else begin
                  word_byte(CH_DOLLAR);
                  lex_st = in_dq ? ST_DQ : ST_WORD;
                  again  = 1'b1;
               end
            end
            ST_NAME, ST_DQ_NAME: begin
               if (name_rest(c)) begin
                  push_token(KIND_NAME_BYTE, c, 2'd0, '0, 2'd0);
               end else begin
                  push_token(KIND_NAME_END, 8'd0, 2'd0, '0, 2'd0);
                  lex_st = (lex_st == ST_NAME) ? ST_WORD : ST_DQ;
                  again  = 1'b1;
               end
            end
            ST_AMP, ST_BAR: begin
               if ((lex_st == ST_AMP && c == CH_AMP) || (lex_st == ST_BAR && c == CH_BAR)) begin
                  close_command((lex_st == ST_AMP) ? SEP_AND : SEP_OR);
                  lex_st = ST_SPACE;
               end else begin
                  abort_line(ERR_OPERATOR, c);
               end
            end
            ST_COMMENT: begin
               if (c == CH_NUL) begin
                  close_command(SEP_LINE);
                  lex_st = ST_SPACE;
               end
            end
            ST_DROP: begin
               if (c == CH_NUL) lex_st = ST_SPACE;
            end
            default: begin
               lex_st = ST_SPACE;
               if (is_blank(c)) begin
               end else if (c == CH_NUL) begin
                  close_command(SEP_LINE);
               end else if (c == CH_HASH) begin
                  lex_st = ST_COMMENT;
               end else if (c == CH_SEMI) begin
                  close_command(SEP_SEMI);
               end else if (c == CH_AMP) begin
                  lex_st = ST_AMP;
               end else if (c == CH_BAR) begin
                  lex_st = ST_BAR;
               end else if (int'(word_cnt) >= MAX_WORDS) begin
                  abort_line(ERR_WORDS, c);
               end else begin
                  in_word  = 1'b1;
                  word_len = 8'd0;
                  quoted   = 1'b0;
                  lex_st   = ST_WORD;
                  again    = 1'b1;
               end
            end
         endcase
         if (!again) break;
      end
      if (char_tokens.size() != 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
      foreach (char_tokens[i]) expected_tokens.push_back(char_tokens[i]);
   endfunction

   always @(posedge clock) begin
      token_t want;
      if (reset) begin
         expected_tokens.delete();
         lex_st     = ST_SPACE;
         word_len   = 8'd0;
         word_cnt   = '0;
         quoted     = 1'b0;
         in_word    = 1'b0;
         status     = 8'd0;
         fail_tally = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               if (fail_tally < 10)
                  $display("unexpected result: kind %0d byte %02h sep %0d total %0d err %0d last %0b",
                           rsp_kind, rsp_out_byte, rsp_sep_code, rsp_word_total,
                           rsp_error_code, rsp_last);
               fail_tally++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_kind != want.kind || rsp_out_byte != want.out_byte ||
                   rsp_sep_code != want.sep_code || rsp_word_total != want.word_total ||
                   rsp_error_code != want.error_code || rsp_last != want.last) begin
                  if (fail_tally < 10) begin
                     $display("mismatch: expected kind %0d byte %02h sep %0d total %0d err %0d last %0b",
                              want.kind, want.out_byte, want.sep_code, want.word_total,
                              want.error_code, want.last);
                     $display("          actual   kind %0d byte %02h sep %0d total %0d err %0d last %0b",
                              rsp_kind, rsp_out_byte, rsp_sep_code, rsp_word_total,
                              rsp_error_code, rsp_last);
                  end
                  fail_tally++;
               end
            end
         end
         if (csr_valid && csr_ready) status = csr_last_status;
         if (req_valid && req_ready) lex_char(req_char_in);
      end
      failures <= fail_tally;
      pending  <= expected_tokens.size();
   end

endmodule

>>> test/testbench.sv
// top of the lexer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
   import shlex_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_PCT     = 7;
   localparam int RANDOM_ITEMS = 280;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_ready;
   logic [7:0]        req_char_in     = 8'd0;
   logic              rsp_valid;
   logic              rsp_ready       = 1'b0;
   logic [2:0]        rsp_kind;
   logic [7:0]        rsp_out_byte;
   logic [1:0]        rsp_sep_code;
   logic [WCNT_W-1:0] rsp_word_total;
   logic [1:0]        rsp_error_code;
   logic              rsp_last;
   logic              csr_valid       = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_last_status = 8'd0;

   int         failures;
   int         pending;
   int         idle_pct     = IDLE_PCT;
   logic       hold_trigger = 1'b0;
   logic       hold_done    = 1'b0;
   int         hold_left    = 0;
   int         cycle_count  = 0;
   int         items_sent   = 0;
   logic [7:0] line_buf[$];

   shell_command_line_lexer_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_sep_code    (rsp_sep_code),
      .rsp_word_total  (rsp_word_total),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_last_status (csr_last_status)
   );

   shlex_checker token_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_sep_code    (rsp_sep_code),
      .rsp_word_total  (rsp_word_total),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_last_status (csr_last_status),
      .failures        (failures),
      .pending         (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_trigger && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_char(line_buf[i]);
      line_buf.delete();
   endtask

   task automatic write_status(input logic [7:0] v);
      csr_valid       <= 1'b1;
      csr_last_status <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic void load_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(33, 255));
      while (b == CH_DQUOTE || b == CH_HASH || b == CH_DOLLAR || b == CH_AMP ||
             b == CH_SQUOTE || b == CH_SEMI || b == CH_BSLASH || b == CH_BAR);
      return b;
   endfunction

   function automatic logic [7:0] name_byte(bit digits_ok);
      case ($urandom_range(0, digits_ok ? 3 : 2))
         0: return CH_UPPER_A + 8'($urandom_range(0, 25));
         1: return CH_LOWER_A + 8'($urandom_range(0, 25));
         2: return CH_UNDER;
         default: return CH_ZERO + 8'($urandom_range(0, 9));
      endcase
   endfunction

   function automatic void add_name();
      int n;
      n = $urandom_range(0, 4);
      line_buf.push_back(CH_DOLLAR);
      line_buf.push_back(name_byte(1'b0));
      repeat (n) line_buf.push_back(name_byte(1'b1));
   endfunction

   function automatic void add_word();
      int pieces;
      int n;
      logic [7:0] b;
      pieces = $urandom_range(1, 3);
      repeat (pieces) begin
         case ($urandom_range(0, 9))
            2: begin
               line_buf.push_back(CH_SQUOTE);
               n = $urandom_range(0, 3);
               repeat (n) begin
                  do b = 8'($urandom_range(1, 255)); while (b == CH_SQUOTE);
                  line_buf.push_back(b);
               end
               line_buf.push_back(CH_SQUOTE);
            end
            3: begin
               line_buf.push_back(CH_DQUOTE);
               n = $urandom_range(0, 3);
               repeat (n) begin
                  case ($urandom_range(0, 5))
                     0: line_buf.push_back(plain_byte());
                     1: begin
                        line_buf.push_back(CH_BSLASH);
                        case ($urandom_range(0, 2))
                           0: line_buf.push_back(CH_DQUOTE);
                           1: line_buf.push_back(CH_BSLASH);
                           default: line_buf.push_back(CH_DOLLAR);
                        endcase
                     end
                     2: begin
                        line_buf.push_back(CH_BSLASH);
                        line_buf.push_back(plain_byte());
                     end
                     3: load_text("$?");
                     4: add_name();
                     default: begin
                        line_buf.push_back(CH_DOLLAR);
                        line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                     end
                  endcase
               end
               line_buf.push_back(CH_DQUOTE);
            end
            4: begin
               line_buf.push_back(CH_BSLASH);
               line_buf.push_back(8'($urandom_range(1, 255)));
            end
            5: load_text("$?");
            6: add_name();
            7: begin
               line_buf.push_back(CH_DOLLAR);
               line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            8: load_text("\"\"");
            default: begin
               n = $urandom_range(1, 4);
               repeat (n) line_buf.push_back(plain_byte());
            end
         endcase
      end
   endfunction

   function automatic void add_blank();
      line_buf.push_back($urandom_range(0, 3) == 0 ? CH_TAB : CH_SPACE);
   endfunction

   function automatic void build_line();
      int mode;
      int cmds;
      int words;
      int n;
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
         cmds = $urandom_range(1, 3);
         for (int c = 0; c < cmds; c++) begin
            if (c != 0) begin
               case ($urandom_range(0, 2))
                  0: load_text(";");
                  1: load_text("&&");
                  default: load_text("||");
               endcase
               if ($urandom_range(0, 1) == 0) add_blank();
            end
            words = $urandom_range(0, 4);
            for (int w = 0; w < words; w++) begin
               add_word();
               if (w != words - 1 || $urandom_range(0, 1) == 0) add_blank();
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            line_buf.push_back(CH_HASH);
            n = $urandom_range(0, 4);
            repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
         end
      end else if (mode < 85) begin
         n = $urandom_range(1, 10);
         repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
      end else begin
         words = $urandom_range(0, 2);
         repeat (words) begin
            add_word();
            add_blank();
         end
         case ($urandom_range(0, 4))
            0: begin
               line_buf.push_back(CH_AMP);
               line_buf.push_back(plain_byte());
            end
            1: line_buf.push_back(CH_BAR);
            2: line_buf.push_back(CH_SQUOTE);
            3: line_buf.push_back(CH_DQUOTE);
            default: line_buf.push_back(CH_BSLASH);
         endcase
         if (line_buf[line_buf.size() - 1] != CH_BSLASH) begin
            n = $urandom_range(0, 4);
            repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
         end
      end
      line_buf.push_back(CH_NUL);
   endfunction

   initial begin
      int rand_base;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_status(8'd255);

      // empty quoted word, lone dollar, status digits, double-quote escapes, name, comment
      load_text("'' $ $?a\"\\q\\$$B9\" #c");
      line_buf.push_back(CH_NUL);
      send_line();
      // lone ampersand mid-line, rest dropped
      load_text("&x|");
      line_buf.push_back(CH_NUL);
      send_line();
      // and, or, empty command, high byte, tab, trailing backslash at line end
      load_text("a&&b||;");
      line_buf.push_back(8'hFF);
      line_buf.push_back(CH_TAB);
      load_text("b\\");
      line_buf.push_back(CH_NUL);
      send_line();
      load_text("\"x");
      line_buf.push_back(CH_NUL);
      send_line();
      load_text("|");
      line_buf.push_back(CH_NUL);
      send_line();
      settle();

      write_status(8'd0);
      rand_base = items_sent;
      idle_pct  = 0;
      while (items_sent - rand_base < RANDOM_ITEMS / 3) begin
         build_line();
         send_line();
      end
      idle_pct = IDLE_PCT;
      while (items_sent - rand_base < RANDOM_ITEMS / 2) begin
         build_line();
         send_line();
      end
      settle();

      write_status(8'($urandom_range(10, 99)));
      hold_trigger <= 1'b1;
      while (items_sent - rand_base < RANDOM_ITEMS) begin
         build_line();
         send_line();
      end
      settle();

      write_status(8'($urandom_range(100, 254)));
      // word cut: status digits and later bytes past the capacity are dropped
      repeat (253) line_buf.push_back(plain_byte());
      load_text("$?xyz$N1 \"\"");
      line_buf.push_back(CH_NUL);
      send_line();
      // a full command of MAX_WORDS words, then one word too many
      repeat (MAX_WORDS) load_text("w ");
      load_text(";");
      repeat (MAX_WORDS + 1) load_text("w ");
      load_text("yz");
      line_buf.push_back(CH_NUL);
      send_line();
      settle();

      if (failures == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
